FILE: design/bus_volume_fader_unit_assert.svh
// assertion macros for the bus volume fader unit
`ifndef BUS_VOLUME_FADER_UNIT_ASSERT_SVH
`define BUS_VOLUME_FADER_UNIT_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define BVF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define BVF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/bvf_pkg.sv
// ----------------------------------------------------------------------------
// bvf_pkg
// types and constants shared by the bus volume fader modules
// ----------------------------------------------------------------------------
package bvf_pkg;

    localparam logic [15:0] UNITY       = 16'd32768;
    localparam logic [23:0] ELAPSED_MAX = 24'hFFFFFF;

    typedef enum logic [2:0] {
        CMD_SET    = 3'd0,
        CMD_MUTE   = 3'd1,
        CMD_UNMUTE = 3'd2,
        CMD_FADE   = 3'd3,
        CMD_TICK   = 3'd4,
        CMD_GAIN   = 3'd5,
        CMD_RSVD6  = 3'd6,   // unused, no effect
        CMD_RSVD7  = 3'd7    // unused, no effect
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_GAIN1,
        ST_GAIN2,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input item
        logic exec;      // apply non-tick command / start tick bus
        logic div_start; // start divider for current bus
        logic div_step;  // one divider step
        logic tick_wb;   // write back tick result of current bus
        logic next_bus;  // advance tick bus index
        logic gain1;     // first gain product
        logic gain2;     // second gain product
        logic out_load;  // present result
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic is_gain;
        logic bus_active;  // current tick bus needs the divider
        logic last_bus;
        logic div_done;
    } stat_t;

endpackage

FILE: design/bvf_ctrl.sv
// ----------------------------------------------------------------------------
// bvf_ctrl
// sequencer: one item at a time, tick walks all buses, the fading ones through the divider
// ----------------------------------------------------------------------------
module bvf_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            out_valid,
    input  logic            out_ready,
    input  bvf_pkg::stat_t  stat,
    output bvf_pkg::ctrl_t  ctrl
);

    bvf_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bvf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // output register free when empty or being drained
    logic out_free;
    assign out_free = !out_valid || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bvf_pkg::ST_IDLE:
            begin
                if (in_valid) state_next = bvf_pkg::ST_EXEC;
            end
            bvf_pkg::ST_EXEC:
            begin
                if (stat.is_tick)
                begin
                    if (stat.bus_active) state_next = bvf_pkg::ST_DIV;
                    else if (stat.last_bus) state_next = bvf_pkg::ST_DONE;
                end
                else if (stat.is_gain) state_next = bvf_pkg::ST_GAIN1;
                else state_next = bvf_pkg::ST_DONE;
            end
            bvf_pkg::ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = stat.last_bus ? bvf_pkg::ST_DONE : bvf_pkg::ST_EXEC;
                end
            end
            bvf_pkg::ST_GAIN1: state_next = bvf_pkg::ST_GAIN2;
            bvf_pkg::ST_GAIN2: state_next = bvf_pkg::ST_DONE;
            bvf_pkg::ST_DONE:
            begin
                if (out_free) state_next = bvf_pkg::ST_IDLE;
            end
            default: state_next = bvf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl     = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            bvf_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                ctrl.load = in_valid;
            end
            bvf_pkg::ST_EXEC:
            begin
                ctrl.exec = 1'b1;
                if (stat.is_tick)
                begin
                    ctrl.div_start = stat.bus_active;
                    ctrl.next_bus  = !stat.bus_active;
                end
            end
            bvf_pkg::ST_DIV:
            begin
                ctrl.div_step = 1'b1;
                if (stat.div_done)
                begin
                    ctrl.tick_wb  = 1'b1;
                    ctrl.next_bus = 1'b1;
                end
            end
            bvf_pkg::ST_GAIN1: ctrl.gain1 = 1'b1;
            bvf_pkg::ST_GAIN2: ctrl.gain2 = 1'b1;
            bvf_pkg::ST_DONE:  ctrl.out_load = out_free;
            default: ;
        endcase
    end

endmodule

FILE: design/bvf_dpath.sv
// ----------------------------------------------------------------------------
// bvf_dpath
// bus state registers, restoring divider, gain multipliers, output register
// ----------------------------------------------------------------------------
module bvf_dpath #(
    parameter int NUM_BUSES = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [2:0]      cmd,
    input  logic [1:0]      bus,
    input  logic [15:0]     level,
    input  logic [23:0]     duration,
    input  logic [15:0]     delta,
    input  logic            master_we,
    input  logic [15:0]     master_wdata,
    input  bvf_pkg::ctrl_t  ctrl,
    output bvf_pkg::stat_t  stat,
    input  logic            out_ready,
    output logic            out_valid,
    output logic [15:0]     bus_volume,
    output logic [15:0]     gain,
    output logic            muted,
    output logic            fading,
    output logic [3:0]      fade_done_mask
);

    localparam int BW = (NUM_BUSES > 1) ? $clog2(NUM_BUSES) : 1;

    logic [15:0] master_reg;
    logic [15:0] lvl_reg  [NUM_BUSES];
    logic        mute_reg [NUM_BUSES];
    logic        act_reg  [NUM_BUSES];
    logic [15:0] start_reg[NUM_BUSES];
    logic [15:0] tgt_reg  [NUM_BUSES];
    logic [23:0] len_reg  [NUM_BUSES];
    logic [23:0] el_reg   [NUM_BUSES];

    logic [2:0]  cmd_reg;
    logic [1:0]  bus_reg;
    logic [15:0] level_reg;
    logic [23:0] dur_reg;
    logic [15:0] delta_reg;
    logic [BW-1:0] tb_reg;
    logic [3:0]  done_reg;

    // divider: (diff * e) / len, quotient fits 16 bits
    logic [39:0] num_reg;
    logic [23:0] den_reg;
    logic [24:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic [23:0] enew_reg;
    logic        full_reg; // elapsed reached length

    logic [31:0] p1_reg;
    logic [15:0] gain_reg;

    // addressed bus
    logic          valid_bus;
    logic [BW-1:0] ab;
    assign valid_bus = ({30'd0, bus_reg} < 32'(NUM_BUSES));
    assign ab        = BW'(bus_reg);

    function automatic logic [15:0] eff(input logic m, input logic a, input logic [15:0] l,
                                        input logic [23:0] n);
        logic [15:0] r;
        begin
            r = l;
            if (m) r = 16'd0;
            else if (a && n != 24'd0) r = l;
            eff = r;
        end
    endfunction

    // lvl_reg holds the current fade point (updated at each tick with nonzero delta)
    logic [15:0] ab_eff;
    assign ab_eff = eff(mute_reg[ab], act_reg[ab], lvl_reg[ab], len_reg[ab]);

    logic [15:0] lvl_sat, master_sat;
    assign lvl_sat    = (level_reg > bvf_pkg::UNITY) ? bvf_pkg::UNITY : level_reg;
    assign master_sat = (master_reg > bvf_pkg::UNITY) ? bvf_pkg::UNITY : master_reg;

    // tick bus setup
    logic [24:0] esum;
    logic [23:0] esat;
    assign esum = {1'b0, el_reg[tb_reg]} + {9'd0, delta_reg};
    assign esat = esum[24] ? bvf_pkg::ELAPSED_MAX : esum[23:0];
    logic        up;
    logic [15:0] diff;
    assign up   = tgt_reg[tb_reg] >= start_reg[tb_reg];
    assign diff = up ? (tgt_reg[tb_reg] - start_reg[tb_reg])
                     : (start_reg[tb_reg] - tgt_reg[tb_reg]);

    logic [24:0] rsh;
    logic [24:0] rsub;
    assign rsh  = {rem_reg[23:0], num_reg[39]};
    assign rsub = rsh - {1'b0, den_reg};

    assign stat.is_tick    = (cmd_reg == bvf_pkg::CMD_TICK);
    assign stat.is_gain    = (cmd_reg == bvf_pkg::CMD_GAIN) && valid_bus;
    assign stat.bus_active = act_reg[tb_reg] && (delta_reg != 16'd0);
    assign stat.last_bus   = ({{(32-BW){1'b0}}, tb_reg} == 32'(NUM_BUSES - 1));
    assign stat.div_done   = (cnt_reg == 6'd40);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_reg <= bvf_pkg::UNITY;
            for (int i = 0; i < NUM_BUSES; i++)
            begin
                lvl_reg[i]   <= bvf_pkg::UNITY;
                mute_reg[i]  <= 1'b0;
                act_reg[i]   <= 1'b0;
                start_reg[i] <= bvf_pkg::UNITY;
                tgt_reg[i]   <= bvf_pkg::UNITY;
                len_reg[i]   <= 24'd0;
                el_reg[i]    <= 24'd0;
            end
            out_valid <= 1'b0;
            tb_reg    <= '0;
            done_reg  <= 4'd0;
            cnt_reg   <= 6'd0;
        end
        else
        begin
            if (master_we) master_reg <= master_wdata;
            if (ctrl.load)
            begin
                cmd_reg   <= cmd;
                bus_reg   <= bus;
                level_reg <= level;
                dur_reg   <= duration;
                delta_reg <= delta;
                tb_reg    <= '0;
                done_reg  <= 4'd0;
                gain_reg  <= 16'd0;
            end
            if (ctrl.exec && !stat.is_tick && valid_bus)
            begin
                case (cmd_reg)
                    bvf_pkg::CMD_SET:
                    begin
                        lvl_reg[ab]  <= lvl_sat;
                        mute_reg[ab] <= 1'b0;
                        act_reg[ab]  <= 1'b0;
                    end
                    bvf_pkg::CMD_MUTE:   mute_reg[ab] <= 1'b1;
                    bvf_pkg::CMD_UNMUTE: mute_reg[ab] <= 1'b0;
                    bvf_pkg::CMD_FADE:
                    begin
                        if (dur_reg == 24'd0)
                        begin
                            lvl_reg[ab]  <= lvl_sat;
                            mute_reg[ab] <= (lvl_sat == 16'd0);
                            act_reg[ab]  <= 1'b0;
                        end
                        else
                        begin
                            start_reg[ab] <= ab_eff;
                            lvl_reg[ab]   <= ab_eff;
                            tgt_reg[ab]   <= lvl_sat;
                            len_reg[ab]   <= dur_reg;
                            el_reg[ab]    <= 24'd0;
                            act_reg[ab]   <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (ctrl.div_start)
            begin
                enew_reg <= esat;
                full_reg <= (esat >= len_reg[tb_reg]);
                num_reg  <= 40'(diff * esat);
                den_reg  <= len_reg[tb_reg];
                rem_reg  <= 25'd0;
                cnt_reg  <= 6'd0;
            end
            if (ctrl.div_step && !stat.div_done)
            begin
                num_reg <= {num_reg[38:0], !rsub[24]};
                rem_reg <= rsub[24] ? rsh : rsub;
                cnt_reg <= cnt_reg + 6'd1;
            end
            if (ctrl.tick_wb)
            begin
                if (full_reg || len_reg[tb_reg] == 24'd0)
                begin
                    lvl_reg[tb_reg] <= tgt_reg[tb_reg];
                    act_reg[tb_reg] <= 1'b0;
                    el_reg[tb_reg]  <= 24'd0;
                    if (tgt_reg[tb_reg] == 16'd0) mute_reg[tb_reg] <= 1'b1;
                    if ({{(32-BW){1'b0}}, tb_reg} < 32'd4)
                        done_reg[2'(tb_reg)] <= 1'b1;
                end
                else
                begin
                    el_reg[tb_reg]  <= enew_reg;
                    lvl_reg[tb_reg] <= up ? (start_reg[tb_reg] + num_reg[15:0])
                                          : (start_reg[tb_reg] - num_reg[15:0]);
                end
            end
            if (ctrl.next_bus && !stat.last_bus) tb_reg <= tb_reg + 1'b1;
            if (ctrl.gain1) p1_reg <= lvl_sat * master_sat;
            if (ctrl.gain2)
            begin
                gain_reg <= ((48'(p1_reg) * ab_eff) >> 30) > 48'(bvf_pkg::UNITY)
                          ? bvf_pkg::UNITY : 16'(((48'(p1_reg) * ab_eff) >> 30));
            end
            if (ctrl.out_load)
            begin
                out_valid      <= 1'b1;
                bus_volume     <= valid_bus ? ab_eff : 16'd0;
                muted          <= valid_bus && mute_reg[ab];
                fading         <= valid_bus && act_reg[ab];
                gain           <= gain_reg;
                fade_done_mask <= done_reg;
            end
            else if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: design/bus_volume_fader_unit.sv
// sequence: accept in IDLE, then EXEC and DONE, where the result is registered; a gain query
// adds GAIN1 and GAIN2; a tick visits each bus in EXEC and sends each fading bus through DIV
// (40-step restoring divider); one item at a time, the next taken in IDLE after the result is
// registered, later while the output register is full and out_ready is low
// reset: rst_n async active low; all buses at unity, unmuted, not fading,
// master at unity
// ----------------------------------------------------------------------------
// bus_volume_fader_unit
// per-bus volume fader with mute, linear fades and gain query
// ----------------------------------------------------------------------------
module bus_volume_fader_unit #(
    parameter int NUM_BUSES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // input item channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [1:0]  bus,
    input  logic [15:0] level,
    input  logic [23:0] duration,
    input  logic [15:0] delta,
    // master volume register
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // result item channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] bus_volume,
    output logic [15:0] gain,
    output logic        muted,
    output logic        fading,
    output logic [3:0]  fade_done_mask
);

    bvf_pkg::ctrl_t ctrl;
    bvf_pkg::stat_t stat;

    // sequencer
    bvf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // bus state and arithmetic
    bvf_dpath #(.NUM_BUSES(NUM_BUSES)) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .bus            (bus),
        .level          (level),
        .duration       (duration),
        .delta          (delta),
        .master_we      (cfg_we),
        .master_wdata   (cfg_wdata),
        .ctrl           (ctrl),
        .stat           (stat),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .bus_volume     (bus_volume),
        .gain           (gain),
        .muted          (muted),
        .fading         (fading),
        .fade_done_mask (fade_done_mask)
    );

endmodule

FILE: design/bvf_checker.sv
// ----------------------------------------------------------------------------
// bvf_checker
// port-level checks of the bus volume fader unit
// ----------------------------------------------------------------------------
`include "bus_volume_fader_unit_assert.svh"

module bvf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] bus_volume,
    input logic [15:0] gain,
    input logic        muted
);

    `BVF_ASSERT_IMPL(a_vol_range, clk, rst_n, out_valid, bus_volume <= 16'd32768)
    `BVF_ASSERT_IMPL(a_gain_range, clk, rst_n, out_valid, gain <= 16'd32768)
    `BVF_ASSERT_IMPL(a_mute_zero, clk, rst_n, out_valid && muted, bus_volume == 16'd0)
    `BVF_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind bus_volume_fader_unit bvf_checker u_bvf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .bus_volume (bus_volume),
    .gain       (gain),
    .muted      (muted)
);

FILE: verif/tb_bus_volume_fader_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bus_volume_fader_unit
// checks the bus volume fader against its own model of the bus state: set,
// mute, unmute, fades, ticks and gain queries under random idling and stalls
// ----------------------------------------------------------------------------
module tb_bus_volume_fader_unit;

    localparam int NB = 4;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  cmd;
    logic [1:0]  bus;
    logic [15:0] level;
    logic [23:0] duration;
    logic [15:0] delta;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] bus_volume;
    logic [15:0] gain;
    logic        muted;
    logic        fading;
    logic [3:0]  fade_done_mask;

    typedef struct packed {
        logic [15:0] vol;
        logic [15:0] gain;
        logic        muted;
        logic        fading;
        logic [3:0]  done;
    } fader_result_t;

    // model of the bus state
    logic [15:0] m_master;
    logic [15:0] m_level [NB];
    logic        m_mute [NB];
    logic        m_fading [NB];
    logic [15:0] m_start [NB];
    logic [15:0] m_target [NB];
    logic [23:0] m_len [NB];
    logic [23:0] m_elapsed [NB];

    fader_result_t pending_results [$];
    int  error_count;
    bit  hold_off;          // long receiver hold-off requested
    int  burst_left;

    bus_volume_fader_unit #(.NUM_BUSES(NB)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .bus(bus), .level(level), .duration(duration), .delta(delta),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .out_valid(out_valid), .out_ready(out_ready),
        .bus_volume(bus_volume), .gain(gain), .muted(muted), .fading(fading),
        .fade_done_mask(fade_done_mask)
    );

    always #5 clk = ~clk;

    function automatic logic [15:0] clamp_unity(input logic [63:0] v);
        return (v > 64'd32768) ? 16'd32768 : v[15:0];
    endfunction

    // linear fade position, quotient truncated
    function automatic logic [15:0] fade_position(input int b);
        logic [63:0] s, t, len, e;
        s = m_start[b];
        t = m_target[b];
        len = m_len[b];
        e = m_elapsed[b];
        if (len == 0 || e >= len)
            return t[15:0];
        if (t >= s)
            return 16'(s + ((t - s) * e) / len);
        return 16'(s - ((s - t) * e) / len);
    endfunction

    function automatic logic [15:0] audible_volume(input int b);
        if (m_mute[b])
            return 16'd0;
        if (m_fading[b] && m_len[b] != 0)
            return fade_position(b);
        return m_level[b];
    endfunction

    function automatic void reset_model();
        m_master = bvf_pkg::UNITY;
        for (int b = 0; b < NB; b++)
        begin
            m_level[b] = bvf_pkg::UNITY;
            m_mute[b] = 1'b0;
            m_fading[b] = 1'b0;
            m_start[b] = bvf_pkg::UNITY;
            m_target[b] = bvf_pkg::UNITY;
            m_len[b] = '0;
            m_elapsed[b] = '0;
        end
    endfunction

    // apply one command to the model and return the result it causes
    function automatic fader_result_t apply_command(input logic [2:0] c, input logic [1:0] b,
                                                    input logic [15:0] lv_raw,
                                                    input logic [23:0] dur,
                                                    input logic [15:0] dt);
        fader_result_t r;
        logic [15:0] lv;
        logic [63:0] p;
        logic [24:0] e;
        lv = clamp_unity(lv_raw);
        r = '0;
        if (c == bvf_pkg::CMD_TICK)
        begin
            if (dt != 0)
            begin
                for (int i = 0; i < NB; i++)
                begin
                    if (!m_fading[i])
                        continue;
                    e = m_elapsed[i] + dt;
                    m_elapsed[i] = (e > bvf_pkg::ELAPSED_MAX) ? bvf_pkg::ELAPSED_MAX : e[23:0];
                    m_level[i] = fade_position(i);
                    if (m_len[i] == 0 || m_elapsed[i] >= m_len[i])
                    begin
                        m_fading[i] = 1'b0;
                        m_elapsed[i] = '0;
                        if (m_target[i] == 0)
                            m_mute[i] = 1'b1;
                        r.done[i] = 1'b1;
                    end
                end
            end
        end
        else
        begin
            case (c)
                bvf_pkg::CMD_SET:
                begin
                    m_level[b] = lv;
                    m_mute[b] = 1'b0;
                    m_fading[b] = 1'b0;
                end
                bvf_pkg::CMD_MUTE:   m_mute[b] = 1'b1;
                bvf_pkg::CMD_UNMUTE: m_mute[b] = 1'b0;
                bvf_pkg::CMD_FADE:
                begin
                    if (dur == 0)
                    begin
                        m_level[b] = lv;
                        m_mute[b] = (lv == 0);
                        m_fading[b] = 1'b0;
                    end
                    else
                    begin
                        m_start[b] = audible_volume(b);
                        m_target[b] = lv;
                        m_len[b] = dur;
                        m_elapsed[b] = '0;
                        m_fading[b] = 1'b1;
                    end
                end
                bvf_pkg::CMD_GAIN:
                begin
                    p = 64'(lv) * 64'(clamp_unity(m_master));
                    p = p * 64'(audible_volume(b));
                    r.gain = clamp_unity(p >> 30);
                end
                default: ;
            endcase
        end
        r.vol = audible_volume(b);
        r.muted = m_mute[b];
        r.fading = m_fading[b];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // sender: bursts of random length with random gaps
    task automatic send_item(input logic [2:0] c, input logic [1:0] b, input logic [15:0] lv,
                             input logic [23:0] dur, input logic [15:0] dt);
        fader_result_t expected;
        in_valid <= 1'b1;
        cmd <= c;
        bus <= b;
        level <= lv;
        duration <= dur;
        delta <= dt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected = apply_command(c, b, lv, dur, dt);
        pending_results = {pending_results, expected};
        burst_left--;
        // end of a burst: maybe idle for a while before the next item
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        // a tick walks all buses, the fading ones through the divider
        repeat (3 + 43 * NB + 20) @(posedge clk);
    endtask

    task automatic write_master(input logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        m_master = v;
    endtask

    function automatic logic [15:0] rand_level();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom_range(32769, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [23:0] rand_duration();
        case ($urandom_range(0, 7))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'($urandom);
            default: return 24'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic logic [15:0] rand_delta();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1, 8));
        endcase
    endfunction

    // extremes of every field, every command and each special case
    task automatic test_directed();
        send_item(bvf_pkg::CMD_GAIN, 2'd0, 16'hFFFF, 24'd0, 16'd0);
        send_item(bvf_pkg::CMD_SET, 2'd1, 16'hFFFF, 24'hFFFFFF, 16'hFFFF);
        send_item(bvf_pkg::CMD_SET, 2'd2, 16'd0, 24'd0, 16'd0);
        send_item(bvf_pkg::CMD_MUTE, 2'd3, 16'd0, 24'd0, 16'd0);
        send_item(bvf_pkg::CMD_GAIN, 2'd3, 16'd32768, 24'd0, 16'd0);
        send_item(bvf_pkg::CMD_UNMUTE, 2'd3, 16'd0, 24'd0, 16'd0);
        // immediate fade to zero mutes
        send_item(bvf_pkg::CMD_FADE, 2'd0, 16'd0, 24'd0, 16'd0);
        // muted start: fades up from 0
        send_item(bvf_pkg::CMD_FADE, 2'd0, 16'd20000, 24'd10, 16'd0);
        // fade down to zero
        send_item(bvf_pkg::CMD_FADE, 2'd1, 16'd0, 24'd7, 16'd0);
        // zero delta does nothing
        send_item(bvf_pkg::CMD_TICK, 2'd0, 16'd0, 24'd0, 16'd0);
        send_item(bvf_pkg::CMD_TICK, 2'd2, 16'd0, 24'd0, 16'd3);
        send_item(bvf_pkg::CMD_GAIN, 2'd1, 16'd32768, 24'd0, 16'd0);
        // bus 1 completes and mutes
        send_item(bvf_pkg::CMD_TICK, 2'd1, 16'd0, 24'd0, 16'd4);
        send_item(bvf_pkg::CMD_FADE, 2'd2, 16'd32768, 24'hFFFFFF, 16'd0);
        send_item(bvf_pkg::CMD_TICK, 2'd2, 16'd0, 24'd0, 16'hFFFF);
        // unused codes
        send_item(bvf_pkg::CMD_RSVD6, 2'd2, 16'h5555, 24'h555555, 16'h5555);
        send_item(bvf_pkg::CMD_RSVD7, 2'd1, 16'hAAAA, 24'hAAAAAA, 16'hAAAA);
        send_item(bvf_pkg::CMD_TICK, 2'd0, 16'd0, 24'd0, 16'd20);
        // set clears mute
        send_item(bvf_pkg::CMD_SET, 2'd0, 16'd12345, 24'd0, 16'd0);
        send_item(bvf_pkg::CMD_GAIN, 2'd0, 16'd40000, 24'd0, 16'd0);
        drain();
    endtask

    // mostly fade sequences driven by ticks, with noise
    task automatic test_random(input int n);
        logic [2:0] c;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0: c = bvf_pkg::CMD_SET;
                1: c = bvf_pkg::CMD_MUTE;
                2: c = bvf_pkg::CMD_UNMUTE;
                3, 4: c = bvf_pkg::CMD_FADE;
                5, 6, 7: c = bvf_pkg::CMD_TICK;
                8: c = bvf_pkg::CMD_GAIN;
                default:
                begin
                    if ($urandom_range(0, 3) != 0)
                        c = bvf_pkg::CMD_GAIN;
                    else if ($urandom_range(0, 1) == 0)
                        c = bvf_pkg::CMD_RSVD6;
                    else
                        c = bvf_pkg::CMD_RSVD7;
                end
            endcase
            send_item(c, 2'($urandom_range(0, 3)), rand_level(), rand_duration(), rand_delta());
        end
    endtask

    task automatic test_master_settings();
        logic [15:0] masters [5] = '{16'd0, 16'd32768, 16'hFFFF, 16'd16384, 16'd1};
        foreach (masters[k])
        begin
            write_master(masters[k]);
            test_random(120);
            drain();
        end
    endtask

    // receiver held off long so the block fills and stalls its input
    task automatic test_backpressure();
        hold_off = 1'b1;
        test_random(20);
        hold_off = 1'b0;
        drain();
    endtask

    // receiver: stall pattern of its own, plus the long hold-off
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            else if ($urandom_range(0, 19) < 4)
                out_ready <= 1'b0;
            else
                out_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        fader_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("unexpected result item at %0t", $realtime);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (bus_volume !== want.vol)
                    report_mismatch("bus_volume", bus_volume, want.vol);
                if (gain !== want.gain)
                    report_mismatch("gain", gain, want.gain);
                if (muted !== want.muted)
                    report_mismatch("muted", 16'(muted), 16'(want.muted));
                if (fading !== want.fading)
                    report_mismatch("fading", 16'(fading), 16'(want.fading));
                if (fade_done_mask !== want.done)
                    report_mismatch("fade_done_mask", 16'(fade_done_mask), 16'(want.done));
            end
        end
    end

    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = '0;
        bus = '0;
        level = '0;
        duration = '0;
        delta = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        error_count = 0;
        hold_off = 1'b0;
        burst_left = 0;
        reset_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_master_settings();
        test_random(100);
        drain();

        if (pending_results.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: bus_volume_fader_unit.f
+incdir+design
design/bvf_pkg.sv
design/bvf_ctrl.sv
design/bvf_dpath.sv
design/bus_volume_fader_unit.sv
design/bvf_checker.sv
verif/tb_bus_volume_fader_unit.sv
